>>> hdl/pmr_pkg.sv
// ----------------------------------------------------------------------------
// Photon map radiance package
// Shared constants, types and elaboration-time tables for the radiance to
// pixel pipeline.
// ----------------------------------------------------------------------------
package pmr_pkg;

  localparam int unsigned OUT_FRAC_BITS = 16;
  localparam int unsigned LOG_FRAC      = 24;
  localparam int unsigned GAMMA_FRAC    = 12;
  localparam int unsigned DIV_BITS      = 32;
  localparam int unsigned NUM_CHAN      = 3;

  // pi in Q2.30
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  // front, divider and sum stages, then the power unit
  localparam int unsigned FRONT_STAGES = 4;
  localparam int unsigned DIV_LATENCY  = FRONT_STAGES + DIV_BITS + 1;
  localparam int unsigned POW_STAGES   = 2 * LOG_FRAC + 3;
  localparam int unsigned PIPE_LATENCY = DIV_LATENCY + POW_STAGES + 1;

  localparam logic [24:0] NUM_PHOTONS_RST = 25'd1;
  localparam logic [15:0] NUM_ROUNDS_RST  = 16'd1;
  localparam logic [15:0] GAMMA_RST       = 16'd1862;
  localparam logic [15:0] LIGHT_RST       = 16'd4096;

  typedef enum logic [2:0] {
    REG_NUM_PHOTONS = 3'd0,
    REG_NUM_ROUNDS  = 3'd1,
    REG_GAMMA       = 3'd2,
    REG_LIGHT_RED   = 3'd3,
    REG_LIGHT_GREEN = 3'd4,
    REG_LIGHT_BLUE  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic valid;
    logic fe;
  } ctrl_t;

  // per-channel payload of the power unit
  typedef struct packed {
    logic        one;
    logic        zero;
    logic [4:0]  lz;
    logic [31:0] m;
    logic [23:0] frac;
    logic [29:0] negl;
    logic [9:0]  n;
    logic [23:0] f;
    logic [32:0] r;
  } pw_t;

  // divider payload, three channels sharing one photon divisor
  typedef struct packed {
    logic [104:0]      e;
    logic              zdiv;
    logic [2:0]        sat;
    logic [2:0][93:0]  arem;
    logic [2:0][31:0]  aq;
    logic [2:0][51:0]  brem;
    logic [2:0][31:0]  bq;
  } dv_t;

  typedef logic [LOG_FRAC:0][31:0] exp_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] vv;
    logic [63:0] res;
    logic [63:0] bt;
    vv  = v;
    res = '0;
    for (int j = 0; j < 32; j++) begin
      bt = 64'd1 << (62 - 2 * j);
      if (vv >= res + bt) begin
        vv  = vv - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // factors 2^(-2^-i) in Q0.32, each the square root of the one before
  function automatic exp_tab_t exp_table();
    exp_tab_t    tab;
    logic [63:0] c;
    c      = 64'd1 << 31;
    tab[0] = c[31:0];
    for (int i = 1; i <= int'(LOG_FRAC); i++) begin
      c      = isqrt64(c << 32);
      tab[i] = c[31:0];
    end
    return tab;
  endfunction

  function automatic logic [4:0] lzc32(input logic [31:0] v);
    logic [4:0] cnt;
    logic       found;
    cnt   = '0;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!found && v[i]) begin
        found = 1'b1;
        cnt   = 5'(31 - i);
      end
    end
    return cnt;
  endfunction

endpackage

>>> hdl/pmr_power.sv
// ----------------------------------------------------------------------------
// Photon map radiance power unit
// Raises three Q0.32 values to the gamma power by log2, multiply and
// exp2, one squaring or one factor per stage, then rounds and clamps.
// ----------------------------------------------------------------------------
module pmr_power import pmr_pkg::*; #(
  parameter int unsigned OutFracBits = OUT_FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ctrl_t                            ctl_i,
  input  logic [NUM_CHAN-1:0][31:0]        x_i,
  input  logic [NUM_CHAN-1:0]              one_i,
  input  logic [NUM_CHAN-1:0]              zero_i,
  input  logic [15:0]                      gamma_i,
  output ctrl_t                            ctl_o,
  output logic [NUM_CHAN-1:0][OutFracBits:0] pix_o
);

  localparam int unsigned NStg   = POW_STAGES;
  localparam int unsigned SNegl  = LOG_FRAC + 1;
  localparam int unsigned SMul   = LOG_FRAC + 2;
  localparam int unsigned SExp0  = LOG_FRAC + 3;
  localparam exp_tab_t    ExpTab = exp_table();
  localparam logic [OutFracBits:0] PixOne = (OutFracBits + 1)'(1) << OutFracBits;
  localparam logic [33:0] RndHalf = 34'd1 << (31 - OutFracBits);

  ctrl_t ctl_q [NStg];
  pw_t   pl_d  [NStg][NUM_CHAN];
  pw_t   pl_q  [NStg][NUM_CHAN];
  logic [NUM_CHAN-1:0][OutFracBits:0] pix_d, pix_q;
  ctrl_t out_ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < int'(NStg); s++) ctl_q[s] <= '0;
      out_ctl_q <= '0;
    end else begin
      ctl_q[0] <= ctl_i;
      for (int s = 1; s < int'(NStg); s++) ctl_q[s] <= ctl_q[s-1];
      out_ctl_q <= ctl_q[NStg-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < int'(NStg); s++) pl_q[s] <= pl_d[s];
    pix_q <= pix_d;
  end

  // normalise
  always_comb begin
    for (int c = 0; c < int'(NUM_CHAN); c++) begin
      pl_d[0][c]      = '0;
      pl_d[0][c].one  = one_i[c];
      pl_d[0][c].zero = zero_i[c];
      pl_d[0][c].lz   = lzc32(x_i[c]);
      pl_d[0][c].m    = x_i[c] << pl_d[0][c].lz;
    end
  end

  // log2 fraction by repeated squaring, one bit a stage
  for (genvar s = 1; s <= int'(LOG_FRAC); s++) begin : g_log
    logic [NUM_CHAN-1:0][63:0] sq;
    always_comb begin
      for (int c = 0; c < int'(NUM_CHAN); c++) begin
        sq[c]      = pl_q[s-1][c].m * pl_q[s-1][c].m;
        pl_d[s][c] = pl_q[s-1][c];
        if (sq[c][63]) begin
          pl_d[s][c].m    = sq[c][63:32];
          pl_d[s][c].frac = {pl_q[s-1][c].frac[22:0], 1'b1};
        end else begin
          pl_d[s][c].m    = sq[c][62:31];
          pl_d[s][c].frac = {pl_q[s-1][c].frac[22:0], 1'b0};
        end
      end
    end
  end

  // -log2(x) in Q.24
  always_comb begin
    for (int c = 0; c < int'(NUM_CHAN); c++) begin
      pl_d[SNegl][c]      = pl_q[SNegl-1][c];
      pl_d[SNegl][c].negl = {({1'b0, pl_q[SNegl-1][c].lz} + 6'd1), 24'd0}
                            - {6'd0, pl_q[SNegl-1][c].frac};
    end
  end

  // scale by gamma
  logic [NUM_CHAN-1:0][45:0] gprod;
  always_comb begin
    for (int c = 0; c < int'(NUM_CHAN); c++) begin
      gprod[c]         = pl_q[SNegl][c].negl * gamma_i;
      pl_d[SMul][c]    = pl_q[SNegl][c];
      pl_d[SMul][c].n  = gprod[c][45:36];
      pl_d[SMul][c].f  = gprod[c][35:12];
      pl_d[SMul][c].r  = 33'h1_0000_0000;
    end
  end

  // exp2 of the fraction, one factor a stage
  for (genvar i = 1; i <= int'(LOG_FRAC); i++) begin : g_exp
    localparam int unsigned S = SExp0 + i - 1;
    logic [NUM_CHAN-1:0][64:0] ep;
    always_comb begin
      for (int c = 0; c < int'(NUM_CHAN); c++) begin
        ep[c]      = pl_q[S-1][c].r * ExpTab[i];
        pl_d[S][c] = pl_q[S-1][c];
        if (pl_q[S-1][c].f[LOG_FRAC-i]) pl_d[S][c].r = ep[c][64:32];
      end
    end
  end

  // integer shift, round half up, clamp
  logic [NUM_CHAN-1:0][32:0] y;
  logic [NUM_CHAN-1:0][33:0] rnd;
  always_comb begin
    for (int c = 0; c < int'(NUM_CHAN); c++) begin
      if (pl_q[NStg-1][c].n >= 10'd33) y[c] = '0;
      else y[c] = pl_q[NStg-1][c].r >> pl_q[NStg-1][c].n[5:0];
      rnd[c] = ({1'b0, y[c]} + RndHalf) >> (32 - OutFracBits);
      if (pl_q[NStg-1][c].one) pix_d[c] = PixOne;
      else if (pl_q[NStg-1][c].zero) pix_d[c] = '0;
      else if (rnd[c] > 34'(PixOne)) pix_d[c] = PixOne;
      else pix_d[c] = rnd[c][OutFracBits:0];
    end
  end

  assign ctl_o = out_ctl_q;
  assign pix_o = pix_q;

endmodule

>>> hdl/photon_map_radiance_to_pixel_top.sv
// ----------------------------------------------------------------------------
// Photon map radiance to pixel
// Forms the photon and direct light radiance estimate per channel, applies
// gamma and clamps to 1.0.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; busy stays low, every stage advances
// each cycle (32 divider stages, 24 log and 24 exp stages).
// Reset clears the valid bits and loads the register defaults.
module photon_map_radiance_to_pixel_top import pmr_pkg::*; #(
  parameter int unsigned OutFracBits = OUT_FRAC_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [31:0]            flux_red_i,
  input  logic [31:0]            flux_green_i,
  input  logic [31:0]            flux_blue_i,
  input  logic [31:0]            direct_red_i,
  input  logic [31:0]            direct_green_i,
  input  logic [31:0]            direct_blue_i,
  input  logic [31:0]            radius_squared_i,
  input  logic                   frame_end_i,
  output logic                   done_o,
  output logic [OutFracBits:0]   out_red_o,
  output logic [OutFracBits:0]   out_green_o,
  output logic [OutFracBits:0]   out_blue_o,
  output logic                   frame_end_out_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [4:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned NCtl = DIV_LATENCY;

  // configuration registers
  logic [24:0] np_q;
  logic [15:0] nr_q, gamma_q;
  logic [NUM_CHAN-1:0][15:0] light_q;
  reg_idx_e    idx;
  logic        wr_en;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      np_q    <= NUM_PHOTONS_RST;
      nr_q    <= NUM_ROUNDS_RST;
      gamma_q <= GAMMA_RST;
      light_q <= {NUM_CHAN{LIGHT_RST}};
    end else if (wr_en) begin
      case (idx)
        REG_NUM_PHOTONS: np_q       <= pwdata[24:0];
        REG_NUM_ROUNDS:  nr_q       <= pwdata[15:0];
        REG_GAMMA:       gamma_q    <= pwdata[15:0];
        REG_LIGHT_RED:   light_q[0] <= pwdata[15:0];
        REG_LIGHT_GREEN: light_q[1] <= pwdata[15:0];
        REG_LIGHT_BLUE:  light_q[2] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_NUM_PHOTONS: prdata = {7'd0, np_q};
      REG_NUM_ROUNDS:  prdata = {16'd0, nr_q};
      REG_GAMMA:       prdata = {16'd0, gamma_q};
      REG_LIGHT_RED:   prdata = {16'd0, light_q[0]};
      REG_LIGHT_GREEN: prdata = {16'd0, light_q[1]};
      REG_LIGHT_BLUE:  prdata = {16'd0, light_q[2]};
      default:         prdata = '0;
    endcase
  end

  // item control travels alongside the data
  logic  accept;
  ctrl_t ctl_q [NCtl];

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < int'(NCtl); s++) ctl_q[s] <= '0;
    end else begin
      ctl_q[0] <= '{valid: accept, fe: frame_end_i};
      for (int s = 1; s < int'(NCtl); s++) ctl_q[s] <= ctl_q[s-1];
    end
  end

  // stage 0: pi * r2, photons * rounds, light * direct
  logic [NUM_CHAN-1:0][31:0] flux_in, dir_in;
  logic [63:0] s0_d_q;
  logic [40:0] s0_npr_q;
  logic        s0_zdiv_q;
  logic [NUM_CHAN-1:0][31:0] s0_flux_q;
  logic [NUM_CHAN-1:0][47:0] s0_bnum_q;

  assign flux_in = {flux_blue_i, flux_green_i, flux_red_i};
  assign dir_in  = {direct_blue_i, direct_green_i, direct_red_i};

  always_ff @(posedge clk_i) begin
    s0_d_q    <= PI_Q30 * radius_squared_i;
    s0_npr_q  <= np_q * nr_q;
    s0_zdiv_q <= (radius_squared_i == '0) || (np_q == '0) || (nr_q == '0);
    s0_flux_q <= flux_in;
    for (int c = 0; c < int'(NUM_CHAN); c++) s0_bnum_q[c] <= light_q[c] * dir_in[c];
  end

  // stage 1: partial products of the photon divisor
  logic [63:0] s1_pp0_q, s1_pp1_q;
  logic [40:0] s1_pp2_q, s1_pp3_q;
  logic        s1_zdiv_q;
  logic [NUM_CHAN-1:0][31:0] s1_flux_q;
  logic [NUM_CHAN-1:0][47:0] s1_bnum_q;

  always_ff @(posedge clk_i) begin
    s1_pp0_q  <= s0_d_q[31:0]  * s0_npr_q[31:0];
    s1_pp1_q  <= s0_d_q[63:32] * s0_npr_q[31:0];
    s1_pp2_q  <= s0_d_q[31:0]  * s0_npr_q[40:32];
    s1_pp3_q  <= s0_d_q[63:32] * s0_npr_q[40:32];
    s1_zdiv_q <= s0_zdiv_q;
    s1_flux_q <= s0_flux_q;
    s1_bnum_q <= s0_bnum_q;
  end

  // stage 2: sum the divisor
  logic [104:0] s2_e_q;
  logic         s2_zdiv_q;
  logic [NUM_CHAN-1:0][31:0] s2_flux_q;
  logic [NUM_CHAN-1:0][47:0] s2_bnum_q;

  always_ff @(posedge clk_i) begin
    s2_e_q <= 105'(s1_pp0_q) + (105'(s1_pp1_q) << 32) + (105'(s1_pp2_q) << 32)
              + (105'(s1_pp3_q) << 64);
    s2_zdiv_q <= s1_zdiv_q;
    s2_flux_q <= s1_flux_q;
    s2_bnum_q <= s1_bnum_q;
  end

  // stage 3: saturation check, load remainders
  dv_t dv_d [DIV_BITS+1];
  dv_t dv_q [DIV_BITS+1];

  always_comb begin
    dv_d[0]      = '0;
    dv_d[0].e    = s2_e_q;
    dv_d[0].zdiv = s2_zdiv_q;
    for (int c = 0; c < int'(NUM_CHAN); c++) begin
      dv_d[0].arem[c] = {s2_flux_q[c], 62'd0};
      dv_d[0].brem[c] = {s2_bnum_q[c], 4'd0};
      dv_d[0].sat[c]  = ({43'd0, s2_flux_q[c], 30'd0} >= s2_e_q)
                        || (s2_bnum_q[c][47:28] >= {4'd0, nr_q});
    end
  end

  // restoring divider, one quotient bit a stage for both terms
  for (genvar s = 1; s <= int'(DIV_BITS); s++) begin : g_div
    localparam int unsigned K = DIV_BITS - s;
    logic [136:0] a_div;
    logic [51:0]  b_div;
    assign a_div = {32'd0, dv_q[s-1].e} << K;
    assign b_div = {36'd0, nr_q} << K;
    always_comb begin
      dv_d[s] = dv_q[s-1];
      for (int c = 0; c < int'(NUM_CHAN); c++) begin
        if ({43'd0, dv_q[s-1].arem[c]} >= a_div) begin
          dv_d[s].arem[c]    = dv_q[s-1].arem[c] - a_div[93:0];
          dv_d[s].aq[c][K]   = 1'b1;
        end
        if (dv_q[s-1].brem[c] >= b_div) begin
          dv_d[s].brem[c]    = dv_q[s-1].brem[c] - b_div;
          dv_d[s].bq[c][K]   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s <= int'(DIV_BITS); s++) dv_q[s] <= dv_d[s];
  end

  // sum of both terms and the special cases
  logic [NUM_CHAN-1:0][32:0] xsum;
  logic [NUM_CHAN-1:0][31:0] sum_x_q;
  logic [NUM_CHAN-1:0]       sum_one_q, sum_zero_q;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < int'(NUM_CHAN); c++) begin
      sum_x_q[c]    <= xsum[c][31:0];
      sum_one_q[c]  <= dv_q[DIV_BITS].zdiv || dv_q[DIV_BITS].sat[c] || xsum[c][32]
                       || (gamma_q == '0);
      sum_zero_q[c] <= (xsum[c][31:0] == '0);
    end
  end

  always_comb begin
    for (int c = 0; c < int'(NUM_CHAN); c++) begin
      xsum[c] = {1'b0, dv_q[DIV_BITS].aq[c]} + {1'b0, dv_q[DIV_BITS].bq[c]};
    end
  end

  ctrl_t pw_ctl;
  logic [NUM_CHAN-1:0][OutFracBits:0] pix;

  pmr_power #(
    .OutFracBits(OutFracBits)
  ) u_power (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_q[NCtl-1]),
    .x_i    (sum_x_q),
    .one_i  (sum_one_q),
    .zero_i (sum_zero_q),
    .gamma_i(gamma_q),
    .ctl_o  (pw_ctl),
    .pix_o  (pix)
  );

  assign done_o          = pw_ctl.valid;
  assign frame_end_out_o = pw_ctl.fe;
  assign out_red_o       = pix[0];
  assign out_green_o     = pix[1];
  assign out_blue_o      = pix[2];

endmodule

>>> hdl/pmr_checker.sv
// ----------------------------------------------------------------------------
// Photon map radiance checker
// Port-level checks of latency, frame-end passage and output range.
// ----------------------------------------------------------------------------
module pmr_checker import pmr_pkg::*; #(
  parameter int unsigned OutFracBits = OUT_FRAC_BITS
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 frame_end_i,
  input logic                 done_o,
  input logic                 frame_end_out_o,
  input logic [OutFracBits:0] out_red_o,
  input logic [OutFracBits:0] out_green_o,
  input logic [OutFracBits:0] out_blue_o
);

  localparam logic [OutFracBits:0] PixOne = (OutFracBits + 1)'(1) << OutFracBits;

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##PIPE_LATENCY done_o)
    else $error("item accepted without a result after the pipeline latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, PIPE_LATENCY))
    else $error("result strobe without a matching item");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && frame_end_i) |-> ##PIPE_LATENCY frame_end_out_o)
    else $error("frame-end mark lost");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_red_o <= PixOne) && (out_green_o <= PixOne)
               && (out_blue_o <= PixOne))
    else $error("pixel above 1.0");

endmodule

bind photon_map_radiance_to_pixel_top pmr_checker #(
  .OutFracBits(OutFracBits)
) u_pmr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .frame_end_i    (frame_end_i),
  .done_o         (done_o),
  .frame_end_out_o(frame_end_out_o),
  .out_red_o      (out_red_o),
  .out_green_o    (out_green_o),
  .out_blue_o     (out_blue_o)
);
